>>> sv/incremental_pid_controller_defines.svh
// ----------------------------------------------------------------------------
// Incremental PID controller: assertion macros
// Shorthand for clocked implications with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_PID_CONTROLLER_DEFINES_SVH
`define INCREMENTAL_PID_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define IPID_ASSERT_NOW(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define IPID_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> sv/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types, register map, mode codes and saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

	// word format: signed Q16.16
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam int ADDR_W = 5;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [2:0] REG_PERIOD_MS  = 3'd3;
	localparam logic [2:0] REG_LOOP_MODE  = 3'd4;
	localparam logic [2:0] REG_DRIVE_LOW  = 3'd5;
	localparam logic [2:0] REG_DRIVE_HIGH = 3'd6;
	localparam logic [2:0] REG_DEAD_BAND  = 3'd7;

	// loop modes
	localparam logic [2:0] MODE_PLAIN    = 3'd0;
	localparam logic [2:0] MODE_CLAMP    = 3'd1;
	localparam logic [2:0] MODE_DEADBAND = 3'd2;
	localparam logic [2:0] MODE_MASTER   = 3'd3;
	localparam logic [2:0] MODE_FOLLOWER = 3'd4;

	// divide by 1000 as multiply by reciprocal: exact for 32-bit dividends
	localparam logic [31:0] DIV_CONST   = 32'd1000;
	localparam logic [28:0] RECIP_1000  = 29'd274877907;
	localparam int          RECIP_SHIFT = 38;

	// cycles from a register write until the coefficients are settled
	localparam logic [2:0] COEF_LAT = 3'd6;

	localparam logic signed [63:0] WORD_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] WORD_MIN = -(64'sd1 <<< (DATA_WIDTH - 1));

	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integ_gain;
		logic signed [31:0] deriv_gain;
		logic [15:0]        period_ms;
		logic [2:0]         loop_mode;
		logic signed [31:0] drive_low;
		logic signed [31:0] drive_high;
		logic [30:0]        dead_band;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] prev;
		logic               busy;
	} coef_t;

	function automatic logic signed [DATA_WIDTH-1:0] sat_word(input logic signed [63:0] v);
		logic signed [DATA_WIDTH-1:0] r;
		if (v > WORD_MAX) begin
			r = WORD_MAX[DATA_WIDTH-1:0];
		end else if (v < WORD_MIN) begin
			r = WORD_MIN[DATA_WIDTH-1:0];
		end else begin
			r = v[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/ipid_cfg.sv
// ----------------------------------------------------------------------------
// ipid_cfg
// APB register file for the controller settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipid_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ipid_pkg::cfg_t               cfg,
	output logic                         wr_stb
);

	logic [2:0] idx;

	assign idx    = paddr[ipid_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_stb = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.prop_gain  <= '0;
			cfg.integ_gain <= '0;
			cfg.deriv_gain <= '0;
			cfg.period_ms  <= 16'd1;
			cfg.loop_mode  <= ipid_pkg::MODE_PLAIN;
			cfg.drive_low  <= 32'sh8000_0000;
			cfg.drive_high <= 32'sh7fff_ffff;
			cfg.dead_band  <= '0;
		end else if (wr_stb) begin
			unique case (idx)
				ipid_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= pwdata;
				ipid_pkg::REG_INTEG_GAIN: cfg.integ_gain <= pwdata;
				ipid_pkg::REG_DERIV_GAIN: cfg.deriv_gain <= pwdata;
				ipid_pkg::REG_PERIOD_MS:  cfg.period_ms  <= pwdata[15:0];
				ipid_pkg::REG_LOOP_MODE:  cfg.loop_mode  <= pwdata[2:0];
				ipid_pkg::REG_DRIVE_LOW:  cfg.drive_low  <= pwdata;
				ipid_pkg::REG_DRIVE_HIGH: cfg.drive_high <= pwdata;
				ipid_pkg::REG_DEAD_BAND:  cfg.dead_band  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ipid_pkg::REG_PROP_GAIN:  prdata = cfg.prop_gain;
			ipid_pkg::REG_INTEG_GAIN: prdata = cfg.integ_gain;
			ipid_pkg::REG_DERIV_GAIN: prdata = cfg.deriv_gain;
			ipid_pkg::REG_PERIOD_MS:  prdata = {16'd0, cfg.period_ms};
			ipid_pkg::REG_LOOP_MODE:  prdata = {29'd0, cfg.loop_mode};
			ipid_pkg::REG_DRIVE_LOW:  prdata = cfg.drive_low;
			ipid_pkg::REG_DRIVE_HIGH: prdata = cfg.drive_high;
			ipid_pkg::REG_DEAD_BAND:  prdata = {1'b0, cfg.dead_band};
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/ipid_coef.sv
// ----------------------------------------------------------------------------
// ipid_coef
// Free-running pipeline that forms the two velocity-form coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_coef (
	input  logic            clk,
	input  logic            arst_n,
	input  ipid_pkg::cfg_t  cfg,
	input  logic            wr_stb,
	output ipid_pkg::coef_t coef
);

	// Ki*T/1000 is split as |Ki| = 1000*a + r, so
	// |Ki|*T/1000 = a*T + floor(r*T/1000): two narrow reciprocal divides.
	logic [31:0]        mag_c;
	logic [60:0]        quo_c;
	logic [31:0]        rem_c;
	logic [54:0]        rq_c;
	logic [38:0]        sum_c;
	logic signed [63:0] cur_c;
	logic signed [63:0] prev_c;

	logic [31:0]        n_s1;
	logic [21:0]        a_s1;
	logic [9:0]         r_s2;
	logic [21:0]        a_s2;
	logic [37:0]        ap_s3;
	logic [25:0]        rp_s3;
	logic [15:0]        rq_s4;
	logic [37:0]        ap_s4;
	logic signed [39:0] q_s5;
	logic signed [31:0] cur_q;
	logic signed [31:0] prev_q;
	logic [2:0]         busy_q;

	always_comb begin
		mag_c  = cfg.integ_gain[31] ? 32'(-cfg.integ_gain) : 32'(cfg.integ_gain);
		quo_c  = 61'(mag_c) * 61'(ipid_pkg::RECIP_1000);
		rem_c  = n_s1 - 32'(a_s1) * ipid_pkg::DIV_CONST;
		rq_c   = 55'(rp_s3) * 55'(ipid_pkg::RECIP_1000);
		sum_c  = 39'(ap_s4) + 39'(rq_s4);
		cur_c  = 64'(cfg.prop_gain) + 64'(cfg.deriv_gain);
		prev_c = 64'(q_s5) - 64'(cfg.prop_gain) - (64'(cfg.deriv_gain) <<< 1);
	end

	always_ff @(posedge clk) begin
		n_s1   <= mag_c;
		a_s1   <= quo_c[ipid_pkg::RECIP_SHIFT +: 22];
		r_s2   <= rem_c[9:0];
		a_s2   <= a_s1;
		ap_s3  <= 38'(a_s2) * 38'(cfg.period_ms);
		rp_s3  <= 26'(r_s2) * 26'(cfg.period_ms);
		rq_s4  <= rq_c[ipid_pkg::RECIP_SHIFT +: 16];
		ap_s4  <= ap_s3;
		q_s5   <= cfg.integ_gain[31] ? -signed'({1'b0, sum_c}) : signed'({1'b0, sum_c});
		cur_q  <= ipid_pkg::sat_word(cur_c);
		prev_q <= ipid_pkg::sat_word(prev_c);
	end

	// settle counter: restarted by reset and by every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= ipid_pkg::COEF_LAT;
		end else if (wr_stb) begin
			busy_q <= ipid_pkg::COEF_LAT;
		end else if (busy_q != 3'd0) begin
			busy_q <= busy_q - 3'd1;
		end
	end

	assign coef.cur  = cur_q;
	assign coef.prev = prev_q;
	assign coef.busy = (busy_q != 3'd0);

endmodule

`default_nettype wire

>>> sv/incremental_pid_controller.sv
// ----------------------------------------------------------------------------
// incremental_pid_controller
// Velocity-form PID with clamp, deadband and haptic master/follower modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_t* (tdata = target, measured; tuser = clear) and
//   one drive word leaves on m_t* for every input word, in order.
//   Settings are written over the APB port while no word is in flight.
// Path: an accepted word passes the input, error, product, sum and drive
//   registers in order; m_tvalid is high while it sits in the drive register.
// Throughput: one word per cycle while m_tready is high and the coefficients
//   are settled; the five stages are separated by registers and only the
//   error and position history and the drive accumulator close loops.
// Reset and register writes: after reset and after each register write,
//   s_tready stays low until the coefficient pipeline has settled, as
//   counted by its settle counter.
// Stalls: each stage advances when the stage after it is empty or moving,
//   so bubbles are squeezed out and input is still taken while a finished
//   word waits on m_tready; a full pipeline stalled there holds s_tready low.
// Reset clears the error, position and drive history.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	// input word
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [63:0]                 s_tdata,   // [31:0] target, [63:32] measured
	input  logic                        s_tuser,   // [0] clear
	// result word
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // [31:0] drive
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ipid_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	// what a word does at the later stages
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_PID     = 2'd1;
	localparam logic [1:0] KIND_HAPTIC  = 2'd2;
	localparam logic [1:0] KIND_CLEAR   = 2'd3;

	ipid_pkg::cfg_t  cfg;
	ipid_pkg::coef_t coef;
	logic            wr_stb;

	ipid_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.wr_stb  (wr_stb)
	);

	ipid_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.wr_stb (wr_stb),
		.coef   (coef)
	);

	// product >> FRAC_BITS, rounded toward zero
	function automatic logic signed [47:0] shift_prod(input logic signed [63:0] p);
		logic signed [63:0] sh;
		logic               fix;
		sh  = p >>> ipid_pkg::FRAC_BITS;
		fix = p[63] && (|p[ipid_pkg::FRAC_BITS-1:0]);
		return 48'(sh) + 48'(fix);
	endfunction

	// ---------------- flow control ----------------
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic en2, en3, en4, en5, ld1, accept;

	assign en5      = !v5_q || m_tready;
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign ld1      = !v1_q || en2;
	assign s_tready = ld1 && !coef.busy;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (ld1) v1_q <= accept;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
		end
	end

	// ---------------- stage 1: input register ----------------
	logic signed [31:0] tgt_s1, mea_s1;
	logic               clr_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_s1 <= s_tdata[31:0];
			mea_s1 <= s_tdata[63:32];
			clr_s1 <= s_tuser;
		end
	end

	// ---------------- stage 2: errors, deadband, history ----------------
	logic signed [31:0] prev_err_q, prev2_err_q, prev_mpos_q, prev_fpos_q;
	logic signed [31:0] err_w, rev_w, pos_mf, pos_fm;
	logic [31:0]        err_abs;
	logic               in_db;
	logic [1:0]         kind_n;
	logic signed [31:0] b0_n, b1_n, b2_n;
	logic               zb_n, clamp_n;

	always_comb begin
		err_w   = ipid_pkg::sat_word(64'(tgt_s1) - 64'(mea_s1));
		rev_w   = ipid_pkg::sat_word(64'(mea_s1) - 64'(tgt_s1));
		pos_mf  = ipid_pkg::sat_word(64'(prev_mpos_q) - 64'(prev_fpos_q));
		pos_fm  = ipid_pkg::sat_word(64'(prev_fpos_q) - 64'(prev_mpos_q));
		err_abs = err_w[31] ? 32'(-err_w) : 32'(err_w);
		in_db   = (cfg.loop_mode == ipid_pkg::MODE_DEADBAND) &&
		          (err_abs <= {1'b0, cfg.dead_band});
		clamp_n = (cfg.loop_mode == ipid_pkg::MODE_CLAMP) ||
		          (cfg.loop_mode == ipid_pkg::MODE_DEADBAND);
		kind_n  = KIND_NONE;
		b0_n    = '0;
		b1_n    = '0;
		b2_n    = '0;
		zb_n    = 1'b0;
		if (clr_s1) begin
			kind_n = KIND_CLEAR;
		end else begin
			case (cfg.loop_mode) inside
				ipid_pkg::MODE_PLAIN, ipid_pkg::MODE_CLAMP, ipid_pkg::MODE_DEADBAND: begin
					kind_n = KIND_PID;
					b0_n   = in_db ? 32'sd0 : err_w;
					b1_n   = prev_err_q;
					b2_n   = prev2_err_q;
					zb_n   = in_db;
				end
				ipid_pkg::MODE_MASTER: begin
					kind_n = KIND_HAPTIC;
					b0_n   = rev_w;
					b1_n   = pos_fm;
				end
				ipid_pkg::MODE_FOLLOWER: begin
					kind_n = KIND_HAPTIC;
					b0_n   = err_w;
					b1_n   = pos_mf;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			prev2_err_q <= '0;
			prev_mpos_q <= '0;
			prev_fpos_q <= '0;
		end else if (en2 && v1_q) begin
			case (kind_n)
				KIND_CLEAR: begin
					prev_err_q  <= '0;
					prev2_err_q <= '0;
				end
				KIND_PID: begin
					prev2_err_q <= prev_err_q;
					prev_err_q  <= b0_n;
				end
				KIND_HAPTIC: begin
					prev_mpos_q <= tgt_s1;
					prev_fpos_q <= mea_s1;
				end
				default: ;
			endcase
		end
	end

	logic signed [31:0] b0_s2, b1_s2, b2_s2;
	logic [1:0]         kind_s2;
	logic               zb_s2, clamp_s2;

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			b0_s2    <= b0_n;
			b1_s2    <= b1_n;
			b2_s2    <= b2_n;
			kind_s2  <= kind_n;
			zb_s2    <= zb_n;
			clamp_s2 <= clamp_n;
		end
	end

	// ---------------- stage 3: three products ----------------
	// PID: cur*e, prev*e1, Kd*e2; haptic: Kp*d, Kd*d1 (third operand is zero)
	logic signed [31:0] a0, a1;
	logic signed [63:0] p0_s3, p1_s3, p2_s3;
	logic [1:0]         kind_s3;
	logic               zb_s3, clamp_s3;

	assign a0 = (kind_s2 == KIND_PID) ? coef.cur  : cfg.prop_gain;
	assign a1 = (kind_s2 == KIND_PID) ? coef.prev : cfg.deriv_gain;

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			p0_s3    <= 64'(a0) * 64'(b0_s2);
			p1_s3    <= 64'(a1) * 64'(b1_s2);
			p2_s3    <= 64'(cfg.deriv_gain) * 64'(b2_s2);
			kind_s3  <= kind_s2;
			zb_s3    <= zb_s2;
			clamp_s3 <= clamp_s2;
		end
	end

	// ---------------- stage 4: scale and sum ----------------
	logic signed [49:0] sum_s4;
	logic [1:0]         kind_s4;
	logic               zb_s4, clamp_s4;

	always_ff @(posedge clk) begin
		if (en4 && v3_q) begin
			sum_s4   <= 50'(shift_prod(p0_s3)) + 50'(shift_prod(p1_s3)) +
			            50'(shift_prod(p2_s3));
			kind_s4  <= kind_s3;
			zb_s4    <= zb_s3;
			clamp_s4 <= clamp_s3;
		end
	end

	// ---------------- stage 5: accumulate, saturate, clamp ----------------
	logic signed [31:0] prev_drive_q, drive_s5;
	logic signed [31:0] base, pid_sat, pid_drv, drv_n;
	logic signed [50:0] tot;

	always_comb begin
		base    = zb_s4 ? 32'sd0 : prev_drive_q;
		tot     = 51'(base) + 51'(sum_s4);
		pid_sat = ipid_pkg::sat_word(64'(tot));
		pid_drv = pid_sat;
		if (clamp_s4) begin
			// with inverted limits, a value above the high limit takes it; any other takes the low limit
			if (pid_sat > cfg.drive_high) begin
				pid_drv = cfg.drive_high;
			end else if (pid_sat < cfg.drive_low) begin
				pid_drv = cfg.drive_low;
			end
		end
		case (kind_s4)
			KIND_PID:    drv_n = pid_drv;
			KIND_HAPTIC: drv_n = ipid_pkg::sat_word(64'(sum_s4));
			default:     drv_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_drive_q <= '0;
		end else if (en5 && v4_q && (kind_s4 != KIND_NONE)) begin
			prev_drive_q <= drv_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v4_q) begin
			drive_s5 <= drv_n;
		end
	end

	assign m_tvalid = v5_q;
	assign m_tdata  = drive_s5;

endmodule

`default_nettype wire

>>> sv/ipid_checker.sv
// ----------------------------------------------------------------------------
// ipid_checker
// Port-level checks on the controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "incremental_pid_controller_defines.svh"

module ipid_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [63:0]                 s_tdata,
	input logic                        s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [31:0]                 m_tdata,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [ipid_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);

	logic cfg_wr, rd_kp, wr_kp;

	assign cfg_wr = psel && penable && pwrite && pready;
	assign rd_kp  = psel && !pwrite && (paddr[ipid_pkg::ADDR_W-1:2] == ipid_pkg::REG_PROP_GAIN);
	assign wr_kp  = cfg_wr && (paddr[ipid_pkg::ADDR_W-1:2] == ipid_pkg::REG_PROP_GAIN);

	// stalled result word holds
	`IPID_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled drive word changed")

	// offered input word holds until taken
	`IPID_ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser), "offered input word changed")

	// a register write stops input while coefficients settle
	`IPID_ASSERT_NEXT(a_wr_blocks_in, clk, arst_n, cfg_wr, !s_tready, "input taken right after a register write")

	// gain written in one cycle reads back in the next
	`IPID_ASSERT_NOW(a_kp_readback, clk, arst_n, rd_kp && $past(wr_kp) && $past(arst_n), prdata == $past(pwdata), "prop_gain readback mismatch")

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (.*);

`default_nettype wire
